>>> sv/gfc_pkg.sv
`default_nettype none
package gfc_pkg;

	localparam int TAPS       = 32;
	localparam int COEF_COUNT = 32;
	localparam int TAP_W      = $clog2(TAPS);

	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 12;
	localparam int GAIN_FRAC  = 8;
	localparam int GPROD_W    = SAMPLE_W + GAIN_W;
	localparam int GCNT_W     = $clog2(SAMPLE_W);
	localparam int SCALED_W   = 16;
	localparam int COEF_W     = 13;
	localparam int COEF_FRAC  = 16;
	localparam int PROD_W     = SCALED_W + COEF_W;
	localparam int ACC_W      = PROD_W + TAP_W;

	localparam int SAMPLE_MAX = 4095;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_DSP_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8       = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAIN,
		ST_FIR,
		ST_DONE
	} state_t;

	localparam logic [COEF_W-1:0] LP_COEF [COEF_COUNT] = '{
		13'd203,  13'd295,  13'd452,  13'd675,  13'd970,  13'd1330, 13'd1750, 13'd2228,
		13'd2746, 13'd3296, 13'd3860, 13'd4417, 13'd4941, 13'd5420, 13'd5826, 13'd6147,
		13'd6364, 13'd6468, 13'd6468, 13'd6364, 13'd6147, 13'd5826, 13'd5420, 13'd4941,
		13'd4417, 13'd3860, 13'd3296, 13'd2746, 13'd2228, 13'd1750, 13'd1330, 13'd970
	};

	// newest sample takes the last used table entry
	function automatic logic [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] age);
		int idx;
		idx = TAPS - 1 - int'(age);
		if (idx < 0 || idx >= COEF_COUNT) begin
			return '0;
		end
		return LP_COEF[idx];
	endfunction

	function automatic logic [SAMPLE_W-1:0] sat_scaled(input logic [SCALED_W-1:0] v);
		if (v > SCALED_W'(SAMPLE_MAX)) begin
			return SAMPLE_W'(SAMPLE_MAX);
		end
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] sat_fir(input logic [ACC_W-1:0] a);
		logic [ACC_W-COEF_FRAC-1:0] v;
		v = a[ACC_W-1:COEF_FRAC];
		if (v > (ACC_W-COEF_FRAC)'(SAMPLE_MAX)) begin
			return SAMPLE_W'(SAMPLE_MAX);
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> sv/gfc_gain_serial.sv
`default_nettype none
module gfc_gain_serial
	import gfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic [GAIN_W-1:0]   gain,
	output logic                     done,
	output logic [SCALED_W-1:0]      scaled
);

	logic [SAMPLE_W-1:0] sr_q;
	logic [GPROD_W-1:0]  acc_q;
	logic [GCNT_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;

	// msb first shift and add, one sample bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == GCNT_W'(SAMPLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= sample;
			acc_q <= '0;
		end else if (busy_q) begin
			sr_q  <= {sr_q[SAMPLE_W-2:0], 1'b0};
			acc_q <= {acc_q[GPROD_W-2:0], 1'b0}
				+ (sr_q[SAMPLE_W-1] ? GPROD_W'(gain) : GPROD_W'(0));
		end
	end

	assign done   = done_q;
	assign scaled = acc_q[GAIN_FRAC +: SCALED_W];

endmodule
`default_nettype wire

>>> sv/gfc_fir_mac.sv
`default_nettype none
module gfc_fir_mac
	import gfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SCALED_W-1:0] scaled,
	output logic                     done,
	output logic [ACC_W-1:0]         acc
);

	logic [SCALED_W-1:0] line_q [TAPS];
	logic [TAP_W-1:0]    age_q;
	logic                busy_q;
	logic [PROD_W-1:0]   prod_s1;
	logic                vld_s1;
	logic                last_s1;
	logic [ACC_W-1:0]    acc_q;
	logic                done_q;

	// delay line circulates one word per cycle past the multiplier tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				line_q[k] <= '0;
			end
		end else if (start) begin
			line_q[0] <= scaled;
			for (int k = 1; k < TAPS; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end else if (busy_q) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				line_q[k] <= line_q[k+1];
			end
			line_q[TAPS-1] <= line_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			age_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (age_q == TAP_W'(TAPS - 1));
			done_q  <= last_s1;
			if (start) begin
				busy_q <= 1'b1;
				age_q  <= '0;
			end else if (busy_q) begin
				age_q <= age_q + 1'b1;
				if (age_q == TAP_W'(TAPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(line_q[0] * tap_coef(age_q));
		if (start) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire

>>> sv/gain_fir_clamp_sample_path_unit.sv
`default_nettype none
// Sample path: gain, optional low-pass FIR, clamp to 0..4095. One sample is
// worked on at a time. Pass-through goes from acceptance to result_q and then
// to the output register; with gain on, the bit-serial gain multiplier takes
// one sample bit per cycle; with the filter on, the circulating delay line
// feeds one multiply-accumulate per cycle. The next sample is taken once
// the result has moved into the output register, even while that register
// is still stalled.
module gain_fir_clamp_sample_path_unit
	import gfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [SAMPLE_W-1:0]   sample_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [SAMPLE_W-1:0]        sample_out
);

	state_t              state_q;
	state_t              state_d;
	logic                dsp_enable_q;
	logic                filter_enable_q;
	logic [GAIN_W-1:0]   gain_q8_q;
	logic [SAMPLE_W-1:0] result_q;
	logic [SAMPLE_W-1:0] result_d;
	logic                result_ld;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_out_q;
	logic                gain_start;
	logic                fir_start;
	logic                out_load;
	logic                gain_done;
	logic [SCALED_W-1:0] scaled;
	logic                fir_done;
	logic [ACC_W-1:0]    fir_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsp_enable_q    <= 1'b0;
			filter_enable_q <= 1'b0;
			gain_q8_q       <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DSP_ENABLE:    dsp_enable_q    <= cfg_data[0];
				CFG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				CFG_GAIN_Q8:       gain_q8_q       <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	gfc_gain_serial u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start),
		.sample (sample_in),
		.gain   (gain_q8_q),
		.done   (gain_done),
		.scaled (scaled)
	);

	gfc_fir_mac u_fir (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fir_start),
		.scaled (scaled),
		.done   (fir_done),
		.acc    (fir_acc)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = dsp_enable_q ? ST_GAIN : ST_DONE;
				end
			end
			ST_GAIN: begin
				if (gain_done) begin
					state_d = filter_enable_q ? ST_FIR : ST_DONE;
				end
			end
			ST_FIR: begin
				if (fir_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		gain_start = 1'b0;
		fir_start  = 1'b0;
		out_load   = 1'b0;
		result_ld  = 1'b0;
		result_d   = sample_in;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				gain_start = in_valid && dsp_enable_q;
				result_ld  = in_valid && !dsp_enable_q;
			end
			ST_GAIN: begin
				fir_start = gain_done && filter_enable_q;
				result_ld = gain_done && !filter_enable_q;
				result_d  = sat_scaled(scaled);
			end
			ST_FIR: begin
				result_ld = fir_done;
				result_d  = sat_fir(fir_acc);
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_ld) begin
			result_q <= result_d;
		end
		if (out_load) begin
			sample_out_q <= result_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule
`default_nettype wire

>>> sv/gfc_checker.sv
`default_nettype none
module gfc_checker
	import gfc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [SAMPLE_W-1:0]   sample_out
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled output transaction changed");

	// one sample at a time: busy right after an input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous sample in flight");

	// a new result only comes out of a busy datapath
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output transaction without work in progress");

endmodule

bind gain_fir_clamp_sample_path_unit gfc_checker u_gfc_checker (.*);
`default_nettype wire

>>> tb/gain_fir_clamp_sample_path_unit_test.sv
`timescale 1ns / 100ps

module gain_fir_clamp_sample_path_unit_test;
	import gfc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int ITEM_TARGET    = 750;
	localparam int CALM_ITEMS     = 100;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 4000;

	// low-pass taps in Q0.16, oldest sample first
	localparam int unsigned LOWPASS_Q16 [32] = '{
		203, 295, 452, 675, 970, 1330, 1750, 2228,
		2746, 3296, 3860, 4417, 4941, 5420, 5826, 6147,
		6364, 6468, 6468, 6364, 6147, 5826, 5420, 4941,
		4417, 3860, 3296, 2746, 2228, 1750, 1330, 970
	};

	class sample_path_scoreboard;
		bit dsp_on;
		bit filter_on;
		logic [GAIN_W-1:0] gain;
		logic [SCALED_W-1:0] history [TAPS];
		logic [SAMPLE_W-1:0] expected_samples [$];
		int errors;

		function new();
			dsp_on = 1'b0;
			filter_on = 1'b0;
			gain = GAIN_W'(256);
			foreach (history[k]) history[k] = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DSP_ENABLE: begin
					dsp_on = data[0];
				end
				CFG_FILTER_ENABLE: begin
					filter_on = data[0];
				end
				CFG_GAIN_Q8: begin
					gain = data[GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [SAMPLE_W-1:0] gain_filter_clamp(logic [SAMPLE_W-1:0] x);
			logic [SAMPLE_W+GAIN_W-1:0] product;
			logic [SCALED_W-1:0] scaled;
			logic [63:0] acc;
			if (!dsp_on) begin
				return x;
			end
			product = x * gain;
			scaled = product[GAIN_FRAC +: SCALED_W];
			if (!filter_on) begin
				return (scaled > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : scaled[SAMPLE_W-1:0];
			end
			for (int k = TAPS - 1; k > 0; k--) begin
				history[k] = history[k - 1];
			end
			history[0] = scaled;
			acc = '0;
			for (int k = 0; k < TAPS; k++) begin
				acc += 64'(LOWPASS_Q16[TAPS - 1 - k]) * 64'(history[k]);
			end
			acc = acc >> COEF_FRAC;
			return (acc > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : acc[SAMPLE_W-1:0];
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] x);
			expected_samples.push_back(gain_filter_clamp(x));
		endfunction

		function void check_sample(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				$error("sample_out: no transaction expected, actual %0d", got);
				errors++;
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending_count();
			return expected_samples.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SAMPLE_W-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SAMPLE_W-1:0] sample_out;

	sample_path_scoreboard sb = new();
	int items_sent = 0;
	int stuck_cycles = 0;
	int stall_odds = 0;
	bit calm = 1'b0;

	gain_fir_clamp_sample_path_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sb.note_sample(sample_in);
		end
		if (out_valid && !out_stall) begin
			sb.check_sample(sample_out);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && stall_odds != 0 && $urandom_range(0, 3 * stall_odds) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("FAIL gain_fir_clamp_sample_path_unit");
		$finish;
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
	endtask

	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] dsp_word,
			input logic [CFG_DATA_W-1:0] filter_word, input logic [CFG_DATA_W-1:0] gain_word,
			input bit poke_unused);
		write_reg(CFG_DSP_ENABLE, dsp_word);
		write_reg(CFG_FILTER_ENABLE, filter_word);
		write_reg(CFG_GAIN_Q8, gain_word);
		if (poke_unused) begin
			write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SAMPLE_W'(SAMPLE_MAX);
			2: return SAMPLE_W'($urandom_range(0, 63));
			3: return SAMPLE_W'($urandom_range(4032, 4095));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return CFG_DATA_W'(26);
			1: return CFG_DATA_W'(2560);
			2: return '0;
			3: return '1;
			4: return CFG_DATA_W'(256);
			5: return CFG_DATA_W'($urandom_range(26, 2560));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	initial begin
		int phase_len;
		int gap_odds;
		int gap;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset: pass-through
		send_sample(12'h000, 0);
		send_sample(12'hFFF, 0);
		send_sample(12'hAAA, 0);
		send_sample(12'h555, 0);

		// filter bit alone leaves pass-through and delay line alone
		settle();
		apply_config(12'h000, 12'h001, 12'd256, 1'b0);
		send_sample(12'hFFF, 0);
		send_sample(12'h001, 0);

		// gain only, extremes and saturation
		settle();
		apply_config(12'h001, 12'h000, 12'd256, 1'b0);
		send_sample(12'hFFF, 0);
		send_sample(12'd123, 0);
		settle();
		apply_config(12'h001, 12'h000, 12'd2560, 1'b0);
		send_sample(12'hFFF, 0);
		send_sample(12'h001, 0);
		settle();
		apply_config(12'h001, 12'h000, 12'd0, 1'b0);
		send_sample(12'hFFF, 0);
		settle();
		apply_config(12'h001, 12'h000, 12'hFFF, 1'b0);
		send_sample(12'hFFF, 0);
		settle();
		apply_config(12'h001, 12'h000, 12'd26, 1'b0);
		send_sample(12'd100, 0);

		// filter with full-scale input then zeros
		settle();
		apply_config(12'h001, 12'h001, 12'hFFF, 1'b0);
		repeat (6) send_sample(12'hFFF, 0);
		repeat (3) send_sample(12'h000, 0);

		// upper data bits dropped, unused index ignored
		settle();
		apply_config(12'hFFE, 12'hFFF, 12'd256, 1'b1);
		send_sample(12'd2000, 0);

		while (items_sent < ITEM_TARGET) begin
			if (!calm) begin
				settle();
				apply_config({11'($urandom), 1'($urandom_range(0, 3) != 0)},
					{11'($urandom), 1'($urandom)}, pick_gain(), $urandom_range(0, 3) == 0);
				gap_odds = $urandom_range(0, 3);
				stall_odds = $urandom_range(0, 3);
			end
			phase_len = $urandom_range(20, 80);
			for (int i = 0; i < phase_len && items_sent < ITEM_TARGET; i++) begin
				if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
					calm = 1'b1;
				end
				gap = 0;
				if (!calm && gap_odds != 0 && $urandom_range(0, 3 * gap_odds) == 0) begin
					gap = $urandom_range(1, 14);
				end
				if (!calm && $urandom_range(0, 79) == 0) begin
					wait_results();
				end
				send_sample(pick_sample(), gap);
			end
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS gain_fir_clamp_sample_path_unit");
		end else begin
			$display("FAIL gain_fir_clamp_sample_path_unit");
		end
		$finish;
	end

endmodule
